>>> src/lcd_pkg.sv
// Types and constants shared by the line crossing detector.
// Holds the register map, the configuration and state records, and reset values.
`timescale 1ns / 1ps

package lcd_pkg;

   localparam int LEVEL_W = 7;
   localparam int TICK_W  = 8;
   localparam int COUNT_W = 3;
   localparam int LIFE_W  = 5;
   localparam int INDEX_W = 3;
   localparam int CSR_W   = 8;

   localparam logic [LEVEL_W-1:0] PEAK_FLOOR     = 7'd0;
   localparam logic [LEVEL_W-1:0] TROUGH_CEILING = 7'd100;
   localparam logic [TICK_W-1:0]  TICK_MAX       = 8'd255;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 3'd7;

   localparam logic [LEVEL_W-1:0] FLAT_SPAN_RST  = 7'd5;
   localparam logic [LEVEL_W-1:0] DARK_LIMIT_RST = 7'd7;
   localparam logic [LEVEL_W-1:0] GRAY_LOW_RST   = 7'd6;
   localparam logic [LEVEL_W-1:0] GRAY_HIGH_RST  = 7'd50;
   localparam logic [TICK_W-1:0]  SETTLE_RST     = 8'd80;
   localparam logic [COUNT_W-1:0] TARGET_RST     = 3'd2;
   localparam logic [LIFE_W-1:0]  RELOAD_RST     = 5'd20;

   typedef enum logic [INDEX_W-1:0] {
      REG_FLAT_SPAN        = 3'd0,
      REG_DARK_LIMIT       = 3'd1,
      REG_GRAY_LOW         = 3'd2,
      REG_GRAY_HIGH        = 3'd3,
      REG_SETTLE_TICKS     = 3'd4,
      REG_TARGET_CROSSINGS = 3'd5,
      REG_LIVENESS_RELOAD  = 3'd6
   } reg_index_type;

   typedef enum logic {
      CMD_TICK    = 1'b0,
      CMD_RESTART = 1'b1
   } command_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] flat_span;
      logic [LEVEL_W-1:0] dark_limit;
      logic [LEVEL_W-1:0] gray_low;
      logic [LEVEL_W-1:0] gray_high;
      logic [TICK_W-1:0]  settle_ticks;
      logic [COUNT_W-1:0] target_crossings;
      logic [LIFE_W-1:0]  liveness_reload;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] peak_level;
      logic [LEVEL_W-1:0] trough_level;
      logic [LIFE_W-1:0]  peak_life;
      logic [LIFE_W-1:0]  trough_life;
      logic [TICK_W-1:0]  elapsed_ticks;
      logic               online_flag;
      logic [COUNT_W-1:0] crossing_count;
   } state_type;

   typedef struct packed {
      logic               done_res;
      logic [COUNT_W-1:0] crossings;
      logic               on_line;
   } result_type;

endpackage

>>> src/lcd_step.sv
// Next-state and result logic for one brightness transaction.
// Purely combinational; uses lcd_pkg for the state, configuration and result records.
`timescale 1ns / 1ps

module lcd_step (
   input  lcd_pkg::cfg_type                  cfg,
   input  lcd_pkg::state_type                state,
   input  logic                              command,
   input  logic [lcd_pkg::LEVEL_W-1:0]       brightness,
   output lcd_pkg::state_type                state_next,
   output lcd_pkg::result_type               result
);

   lcd_pkg::state_type s;
   logic [lcd_pkg::LEVEL_W-1:0] span;
   logic flat;
   logic hit;
   logic gray;
   logic done;

   always_comb begin
      s    = state;
      span = '0;
      flat = 1'b0;
      hit  = 1'b0;
      gray = 1'b0;
      done = 1'b0;

      if (command == lcd_pkg::CMD_RESTART) begin
         s.peak_level     = lcd_pkg::PEAK_FLOOR;
         s.trough_level   = lcd_pkg::TROUGH_CEILING;
         s.peak_life      = cfg.liveness_reload;
         s.trough_life    = cfg.liveness_reload;
         s.elapsed_ticks  = '0;
         s.online_flag    = 1'b0;
         s.crossing_count = '0;
      end else begin
         if (s.elapsed_ticks != lcd_pkg::TICK_MAX) begin
            s.elapsed_ticks = s.elapsed_ticks + 1'b1;
         end

         // a new peak wins over a new trough
         if (brightness > s.peak_level) begin
            s.peak_level = brightness;
            s.peak_life  = cfg.liveness_reload;
         end else if (brightness < s.trough_level) begin
            s.trough_level = brightness;
            s.trough_life  = cfg.liveness_reload;
         end

         span = s.peak_level - s.trough_level;
         flat = (s.peak_level >= s.trough_level) && (span <= cfg.flat_span);
         hit  = flat && (s.peak_level < cfg.dark_limit) && !s.online_flag &&
                (s.elapsed_ticks > cfg.settle_ticks);

         if (hit) begin
            s.online_flag = 1'b1;
            if (s.crossing_count != lcd_pkg::COUNT_MAX) begin
               s.crossing_count = s.crossing_count + 1'b1;
            end
            s.peak_level   = lcd_pkg::PEAK_FLOOR;
            s.trough_level = lcd_pkg::TROUGH_CEILING;
         end

         gray = (s.trough_level > cfg.gray_low) && (s.trough_level < cfg.gray_high);
         done = gray && (s.crossing_count >= cfg.target_crossings);

         if (gray && !done) begin
            s.online_flag = 1'b0;
         end

         // lifetimes freeze on a done tick
         if (!done) begin
            if (s.peak_life != '0) begin
               s.peak_life = s.peak_life - 1'b1;
            end
            if (s.trough_life != '0) begin
               s.trough_life = s.trough_life - 1'b1;
            end
            if (s.peak_life == '0) begin
               s.peak_level = lcd_pkg::PEAK_FLOOR;
            end
            if (s.trough_life == '0) begin
               s.trough_level = lcd_pkg::TROUGH_CEILING;
            end
         end
      end

      state_next       = s;
      result.done_res  = done;
      result.crossings = s.crossing_count;
      result.on_line   = s.online_flag;
   end

endmodule

>>> src/line_crossing_detector.sv
// Line crossing detector top level: stream ports, register file, state and result registers.
// Depends on lcd_pkg and lcd_step.
`timescale 1ns / 1ps

// One transaction on req_ is one brightness sample tick or a restart command; each yields
// exactly one transaction on rsp_. A new sample is taken every cycle while the output side
// keeps up; each sample crosses only the input register, then the state and result register,
// since the whole peak, trough and crossing update is one combinational pass over the stored
// state. Registers are written on the csr_ channel, which is always ready, and should only be
// written while no transaction is in flight.
module line_crossing_detector (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [6:0] brightness, [7] zero
   input  logic                         req_tuser,   // [0] command
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,   // [0] done_res, [3:1] crossings,
                                                     // [4] on_line, [7:5] zero
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lcd_pkg::INDEX_W-1:0]  csr_index,
   input  logic [lcd_pkg::CSR_W-1:0]    csr_data
);

   lcd_pkg::cfg_type    cfg_ff;
   lcd_pkg::state_type  state_ff, state_in;
   lcd_pkg::result_type result_ff, result_in;
   logic                in_valid_ff;
   logic                in_command_ff;
   logic [lcd_pkg::LEVEL_W-1:0] in_brightness_ff;
   logic                out_valid_ff;
   logic                advance;

   assign csr_ready  = 1'b1;
   // advance when the input register holds an item and the result register is empty or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flat_span        <= lcd_pkg::FLAT_SPAN_RST;
         cfg_ff.dark_limit       <= lcd_pkg::DARK_LIMIT_RST;
         cfg_ff.gray_low         <= lcd_pkg::GRAY_LOW_RST;
         cfg_ff.gray_high        <= lcd_pkg::GRAY_HIGH_RST;
         cfg_ff.settle_ticks     <= lcd_pkg::SETTLE_RST;
         cfg_ff.target_crossings <= lcd_pkg::TARGET_RST;
         cfg_ff.liveness_reload  <= lcd_pkg::RELOAD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (lcd_pkg::reg_index_type'(csr_index))
            lcd_pkg::REG_FLAT_SPAN:        cfg_ff.flat_span  <= csr_data[lcd_pkg::LEVEL_W-1:0];
            lcd_pkg::REG_DARK_LIMIT:       cfg_ff.dark_limit <= csr_data[lcd_pkg::LEVEL_W-1:0];
            lcd_pkg::REG_GRAY_LOW:         cfg_ff.gray_low   <= csr_data[lcd_pkg::LEVEL_W-1:0];
            lcd_pkg::REG_GRAY_HIGH:        cfg_ff.gray_high  <= csr_data[lcd_pkg::LEVEL_W-1:0];
            lcd_pkg::REG_SETTLE_TICKS:     cfg_ff.settle_ticks <= csr_data;
            lcd_pkg::REG_TARGET_CROSSINGS: begin
               cfg_ff.target_crossings <= csr_data[lcd_pkg::COUNT_W-1:0];
            end
            lcd_pkg::REG_LIVENESS_RELOAD:  begin
               cfg_ff.liveness_reload <= csr_data[lcd_pkg::LIFE_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_command_ff    <= req_tuser;
         in_brightness_ff <= req_tdata[lcd_pkg::LEVEL_W-1:0];
      end
   end

   lcd_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .command    (in_command_ff),
      .brightness (in_brightness_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.peak_level     <= lcd_pkg::PEAK_FLOOR;
         state_ff.trough_level   <= lcd_pkg::TROUGH_CEILING;
         state_ff.peak_life      <= lcd_pkg::RELOAD_RST;
         state_ff.trough_life    <= lcd_pkg::RELOAD_RST;
         state_ff.elapsed_ticks  <= '0;
         state_ff.online_flag    <= 1'b0;
         state_ff.crossing_count <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, result_ff.on_line, result_ff.crossings, result_ff.done_res};

   // count only moves up between restarts
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (advance && in_command_ff == lcd_pkg::CMD_TICK) |=>
      state_ff.crossing_count >= $past(state_ff.crossing_count))
      else $error("crossing count decreased on a sample tick");

   a_ticks_monotonic: assert property (@(posedge clock) disable iff (reset)
      (advance && in_command_ff == lcd_pkg::CMD_TICK) |=>
      state_ff.elapsed_ticks >= $past(state_ff.elapsed_ticks))
      else $error("elapsed ticks decreased on a sample tick");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_command_ff == lcd_pkg::CMD_RESTART) |=>
      (state_ff.elapsed_ticks == '0 && state_ff.crossing_count == '0 &&
       !state_ff.online_flag && rsp_tvalid && rsp_tdata == 8'd0))
      else $error("restart did not clear state and result");

   a_done_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && result_ff.done_res) |->
      result_ff.crossings >= cfg_ff.target_crossings)
      else $error("done reported below target count");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (result_ff.crossings == state_ff.crossing_count &&
                   result_ff.on_line == state_ff.online_flag))
      else $error("result register out of step with state");

endmodule

>>> test/lcd_crossing_checker.sv
// Checker for the line crossing detector: watches the csr_, req_ and rsp_ channels,
// predicts each result from its own copy of the configuration and state, and compares.
// Depends on lcd_pkg for the register indexes, commands and record types.
`timescale 1ns / 1ps

module lcd_crossing_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [6:0] brightness, [7] zero
   input  logic                         req_tuser,   // [0] command
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [7:0]                   rsp_tdata,   // [0] done_res, [3:1] crossings,
                                                     // [4] on_line, [7:5] zero
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [lcd_pkg::INDEX_W-1:0]  csr_index,
   input  logic [lcd_pkg::CSR_W-1:0]    csr_data,
   output int                           mismatches,
   output int                           outstanding,
   output int                           done_reports
);

   lcd_pkg::cfg_type    regs;
   lcd_pkg::state_type  trk;
   lcd_pkg::result_type crossing_reports_due [$];

   task automatic clear_tracker();
      trk.peak_level     = lcd_pkg::PEAK_FLOOR;
      trk.trough_level   = lcd_pkg::TROUGH_CEILING;
      trk.peak_life      = regs.liveness_reload;
      trk.trough_life    = regs.liveness_reload;
      trk.elapsed_ticks  = '0;
      trk.online_flag    = 1'b0;
      trk.crossing_count = '0;
   endtask

   task automatic predict_crossing(input lcd_pkg::command_type cmd,
                                   input logic [lcd_pkg::LEVEL_W-1:0] level,
                                   output lcd_pkg::result_type rpt);
      int  span;
      logic in_gray;
      rpt = '0;
      if (cmd == lcd_pkg::CMD_RESTART) begin
         clear_tracker();
      end else begin
         if (trk.elapsed_ticks != lcd_pkg::TICK_MAX)
            trk.elapsed_ticks = trk.elapsed_ticks + 1'b1;
         // a new peak wins; only otherwise may the trough move
         if (level > trk.peak_level) begin
            trk.peak_level = level;
            trk.peak_life  = regs.liveness_reload;
         end else if (level < trk.trough_level) begin
            trk.trough_level = level;
            trk.trough_life  = regs.liveness_reload;
         end
         span = int'(trk.peak_level) - int'(trk.trough_level);
         if (span >= 0 && span <= int'(regs.flat_span) && trk.peak_level < regs.dark_limit &&
             !trk.online_flag && trk.elapsed_ticks > regs.settle_ticks) begin
            trk.online_flag = 1'b1;
            if (trk.crossing_count != lcd_pkg::COUNT_MAX)
               trk.crossing_count = trk.crossing_count + 1'b1;
            trk.peak_level   = lcd_pkg::PEAK_FLOOR;
            trk.trough_level = lcd_pkg::TROUGH_CEILING;
         end
         in_gray = trk.trough_level > regs.gray_low && trk.trough_level < regs.gray_high;
         if (in_gray && trk.crossing_count >= regs.target_crossings) begin
            // lifetimes hold on a done tick
            rpt.done_res = 1'b1;
         end else begin
            if (in_gray)
               trk.online_flag = 1'b0;
            if (trk.peak_life != 0)
               trk.peak_life = trk.peak_life - 1'b1;
            if (trk.trough_life != 0)
               trk.trough_life = trk.trough_life - 1'b1;
            if (trk.peak_life == 0)
               trk.peak_level = lcd_pkg::PEAK_FLOOR;
            if (trk.trough_life == 0)
               trk.trough_level = lcd_pkg::TROUGH_CEILING;
         end
         rpt.crossings = trk.crossing_count;
         rpt.on_line   = trk.online_flag;
      end
   endtask

   task automatic compare_field(input string field, input logic [lcd_pkg::COUNT_W-1:0] want,
                                input logic [lcd_pkg::COUNT_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      lcd_pkg::result_type want;
      lcd_pkg::result_type fresh;
      if (reset) begin
         regs.flat_span        = lcd_pkg::FLAT_SPAN_RST;
         regs.dark_limit       = lcd_pkg::DARK_LIMIT_RST;
         regs.gray_low         = lcd_pkg::GRAY_LOW_RST;
         regs.gray_high        = lcd_pkg::GRAY_HIGH_RST;
         regs.settle_ticks     = lcd_pkg::SETTLE_RST;
         regs.target_crossings = lcd_pkg::TARGET_RST;
         regs.liveness_reload  = lcd_pkg::RELOAD_RST;
         clear_tracker();
         crossing_reports_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (lcd_pkg::reg_index_type'(csr_index))
               lcd_pkg::REG_FLAT_SPAN:
                  regs.flat_span        = csr_data[lcd_pkg::LEVEL_W-1:0];
               lcd_pkg::REG_DARK_LIMIT:
                  regs.dark_limit       = csr_data[lcd_pkg::LEVEL_W-1:0];
               lcd_pkg::REG_GRAY_LOW:
                  regs.gray_low         = csr_data[lcd_pkg::LEVEL_W-1:0];
               lcd_pkg::REG_GRAY_HIGH:
                  regs.gray_high        = csr_data[lcd_pkg::LEVEL_W-1:0];
               lcd_pkg::REG_SETTLE_TICKS:
                  regs.settle_ticks     = csr_data[lcd_pkg::TICK_W-1:0];
               lcd_pkg::REG_TARGET_CROSSINGS:
                  regs.target_crossings = csr_data[lcd_pkg::COUNT_W-1:0];
               lcd_pkg::REG_LIVENESS_RELOAD:
                  regs.liveness_reload  = csr_data[lcd_pkg::LIFE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (crossing_reports_due.size() == 0) begin
               mismatches++;
               $display("%0t ns: result mismatch, expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = crossing_reports_due.pop_front();
               compare_field("done_res", want.done_res, rsp_tdata[0]);
               compare_field("crossings", want.crossings, rsp_tdata[3:1]);
               compare_field("on_line", want.on_line, rsp_tdata[4]);
               if (want.done_res)
                  done_reports++;
            end
         end
         if (req_tvalid && req_tready) begin
            predict_crossing(lcd_pkg::command_type'(req_tuser),
                             req_tdata[lcd_pkg::LEVEL_W-1:0], fresh);
            crossing_reports_due.push_back(fresh);
         end
      end
      outstanding <= crossing_reports_due.size();
   end

endmodule

>>> test/tb_line_crossing_detector.sv
// Testbench top for the line crossing detector: clock, reset, sample and register stimulus,
// receiver back-pressure, watchdog and verdict. Depends on lcd_pkg and lcd_crossing_checker.
`timescale 1ns / 1ps

module tb_line_crossing_detector;

   typedef logic [lcd_pkg::LEVEL_W-1:0] level_type;

   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 64;
   localparam int SETTLE_WAIT  = 8;
   localparam int RESTART_MARK = -1;
   // zero and full-scale samples, levels past 100, repeated darks and restarts mid-run
   localparam int PROBE_SEQ [23] = '{RESTART_MARK, 0, 127, 100, 1, 64, 3, 3, 2, 20, 42,
                                     RESTART_MARK, 85, 6, 50, 7, 0, 0, 49, 5, RESTART_MARK,
                                     2, 2};

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [7:0]                  req_tdata;
   logic                        req_tuser;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [7:0]                  rsp_tdata;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [lcd_pkg::INDEX_W-1:0] csr_index;
   logic [lcd_pkg::CSR_W-1:0]   csr_data;

   int mismatches;
   int outstanding;
   int done_reports;
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_token;
   int hold_served;
   int hold_left;
   int idle_cycles;
   int samples_sent;
   int restarts_sent;
   int settings_used;

   always #2 clock = ~clock;

   line_crossing_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lcd_crossing_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .done_reports (done_reports)
   );

   // receiver: random stalls, plus a long hold-off whenever a new token is posted
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_token != hold_served) begin
         hold_served <= hold_token;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("tb_line_crossing_detector: errors");
         $finish;
      end
   end

   task automatic send_item(input lcd_pkg::command_type cmd, input level_type level);
      if ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, level};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      if (cmd == lcd_pkg::CMD_RESTART)
         restarts_sent++;
      else
         samples_sent++;
   endtask

   // drop valid and wait until every result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_register(input lcd_pkg::reg_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[lcd_pkg::CSR_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_settings(input int flat, input int dark, input int glow,
                                   input int ghigh, input int settle, input int target,
                                   input int reload);
      drain();
      write_register(lcd_pkg::REG_FLAT_SPAN, flat);
      write_register(lcd_pkg::REG_DARK_LIMIT, dark);
      write_register(lcd_pkg::REG_GRAY_LOW, glow);
      write_register(lcd_pkg::REG_GRAY_HIGH, ghigh);
      write_register(lcd_pkg::REG_SETTLE_TICKS, settle);
      write_register(lcd_pkg::REG_TARGET_CROSSINGS, target);
      write_register(lcd_pkg::REG_LIVENESS_RELOAD, reload);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // runs of dark, gray and white samples with noise and the odd restart mixed in
   task automatic random_phase(input int count, input int pause_at);
      int        sent;
      int        kind;
      int        len;
      int        base;
      logic      paused;
      level_type level;
      sent   = 0;
      paused = 1'b0;
      send_item(lcd_pkg::CMD_RESTART, level_type'($urandom_range(127)));
      while (sent < count) begin
         if (pause_at >= 0 && sent >= pause_at && !paused) begin
            drain();
            paused = 1'b1;
         end
         kind = $urandom_range(99);
         if (kind < 3) begin
            send_item(lcd_pkg::CMD_RESTART, level_type'($urandom_range(127)));
            sent++;
         end else begin
            len  = (kind < 40) ? $urandom_range(1, 30) : $urandom_range(1, 12);
            base = $urandom_range(0, 9);
            repeat (len) begin
               if (kind < 40)
                  level = level_type'(base + $urandom_range(0, 3));
               else if (kind < 70)
                  level = level_type'($urandom_range(8, 48));
               else if (kind < 88)
                  level = level_type'($urandom_range(55, 100));
               else
                  level = level_type'($urandom_range(0, 127));
               send_item(lcd_pkg::CMD_TICK, level);
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= lcd_pkg::CMD_TICK;
      csr_valid    <= 1'b0;
      csr_index    <= lcd_pkg::REG_FLAT_SPAN;
      csr_data     <= '0;
      rsp_idle_pct <= 85;
      hold_token   <= 0;
      req_idle_pct = 23;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      program_settings(5, 7, 6, 50, 0, 1, 2);
      foreach (PROBE_SEQ[i]) begin
         if (PROBE_SEQ[i] == RESTART_MARK)
            send_item(lcd_pkg::CMD_RESTART, '0);
         else
            send_item(lcd_pkg::CMD_TICK, level_type'(PROBE_SEQ[i]));
      end

      program_settings(5, 7, 6, 50, 80, 2, 20);
      random_phase(400, 200);
      program_settings(0, 0, 0, 0, 0, 1, 1);
      random_phase(150, -1);

      req_idle_pct = 85;
      rsp_idle_pct <= 23;
      program_settings(100, 100, 100, 100, 255, 7, 31);
      random_phase(150, -1);
      program_settings(10, 12, 8, 60, 20, 3, 6);
      random_phase(400, -1);

      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      program_settings(3, 5, 4, 40, 5, 7, 12);
      // stall the receiver while samples keep coming, so the input side backs up
      hold_token <= hold_token + 1;
      random_phase(450, -1);

      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      $display("run covered %0d samples and %0d restarts under %0d register settings,",
               samples_sent, restarts_sent, settings_used);
      $display("with %0d done reports among the checked results", done_reports);
      if (mismatches == 0 && outstanding == 0)
         $display("tb_line_crossing_detector: clean");
      else
         $display("tb_line_crossing_detector: errors");
      $finish;
   end

endmodule

>>> files.f
src/lcd_pkg.sv
src/lcd_step.sv
src/line_crossing_detector.sv
test/lcd_crossing_checker.sv
test/tb_line_crossing_detector.sv
